@@ rtl/rgcp_pkg.sv @@
// Shared types and constants for the radial gradient circle pattern generator.
// Used by rgcp_ctrl, rgcp_datapath and radial_gradient_circle_pattern.
package rgcp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS = 3'd4;

  // Field and counter widths
  localparam int DIM_W   = 13;  // frame_width / frame_height registers
  localparam int POS_W   = 12;  // center registers, output positions
  localparam int RAD_W   = 12;
  localparam int COL_W   = 13;  // column counter
  localparam int ROW_W   = 16;  // row counter wraps at 16 bits
  localparam int SUM_W   = 33;  // dx*dx + dy*dy
  localparam int CHAN_W  = 8;
  localparam int SCALE_W = 18;  // width of the constant multiplier operand
  localparam int NUM_W   = RAD_W + SCALE_W;  // dividend after dropping fraction bits
  localparam int DEN_W   = 22;  // radius * 1000
  localparam int QUO_W   = 8;   // quotient bits, one per divide step

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd256;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd256;
  localparam logic [POS_W-1:0]   CENTER_RESET = 12'd127;
  localparam logic [RAD_W-1:0]   RADIUS_RESET = 12'd60;

  localparam logic [SCALE_W-1:0] GRAD_SCALE = 18'd255999;
  localparam logic [SCALE_W-1:0] DEN_SCALE  = 18'd1000;
  localparam logic [CHAN_W-1:0]  CHAN_FULL  = 8'd255;

  // Operand select of the shared multiplier
  typedef enum logic [2:0] {
    MUL_DX,
    MUL_DY,
    MUL_RAD,
    MUL_DEN,
    MUL_BLUE,
    MUL_GREEN
  } mul_sel_t;

  typedef struct packed {
    logic     step;       // advance counters for an accepted item
    logic     diff;       // form |dx|, |dy| and the frame-end flag
    mul_sel_t mul_sel;
    logic     sum_load;   // sum <= product
    logic     sum_add;    // sum <= sum + product
    logic     cmp;        // in_circle <= sum <= radius^2
    logic     den_load;   // latch denominator, arm the square root
    logic     sqrt_step;
    logic     nb_load;    // blue dividend
    logic     ng_load;    // green dividend, arm the divider
    logic     div_step;
    logic     out_load;
  } rgcp_cmd_t;

  typedef struct packed {
    logic in_circle;
  } rgcp_status_t;

  typedef struct packed {
    logic              frame_end;
    logic [POS_W-1:0]  pixel_row;
    logic [POS_W-1:0]  pixel_col;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgcp_pixel_t;

endpackage

@@ rtl/rgcp_ctrl.sv @@
// Sequencer for one pixel: counter step, squares, compare, square root,
// scaling multiplies and divide. Depends on rgcp_pkg.
module rgcp_ctrl #(
  parameter int ROOT_W = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_free,
  input  rgcp_pkg::rgcp_status_t status,
  output rgcp_pkg::rgcp_cmd_t    cmd
);

  localparam int CntW = $clog2(ROOT_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_SQR,
    S_CMP,
    S_DEN,
    S_SQRT,
    S_MULB,
    S_MULG,
    S_DIVLD,
    S_DIV,
    S_FIN
  } state_t;

  state_t          state;
  logic [CntW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_DIFF;
            in_ready <= 1'b0;
          end
        end
        S_DIFF: state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_SQR;
        S_SQR:  state <= S_CMP;
        S_CMP:  state <= S_DEN;
        S_DEN: begin
          // outside the circle the color is fixed, skip the arithmetic
          if (status.in_circle) begin
            state <= S_SQRT;
            cnt   <= CntW'(ROOT_W - 1);
          end else begin
            state <= S_FIN;
          end
        end
        S_SQRT: begin
          cnt <= cnt - CntW'(1);
          if (cnt == '0) begin
            state <= S_MULB;
          end
        end
        S_MULB: state <= S_MULG;
        S_MULG: state <= S_DIVLD;
        S_DIVLD: begin
          state <= S_DIV;
          cnt   <= CntW'(rgcp_pkg::QUO_W - 1);
        end
        S_DIV: begin
          cnt <= cnt - CntW'(1);
          if (cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output stage has room
          if (out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.step = in_valid && in_ready;
      S_DIFF:  cmd.diff = 1'b1;
      S_SQX:   cmd.mul_sel = rgcp_pkg::MUL_DX;
      S_SQY: begin
        cmd.mul_sel  = rgcp_pkg::MUL_DY;
        cmd.sum_load = 1'b1;
      end
      S_SQR: begin
        cmd.mul_sel = rgcp_pkg::MUL_RAD;
        cmd.sum_add = 1'b1;
      end
      S_CMP: begin
        cmd.mul_sel = rgcp_pkg::MUL_DEN;
        cmd.cmp     = 1'b1;
      end
      S_DEN:   cmd.den_load = 1'b1;
      S_SQRT:  cmd.sqrt_step = 1'b1;
      S_MULB:  cmd.mul_sel = rgcp_pkg::MUL_BLUE;
      S_MULG: begin
        cmd.mul_sel = rgcp_pkg::MUL_GREEN;
        cmd.nb_load = 1'b1;
      end
      S_DIVLD: cmd.ng_load = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN:   cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/rgcp_datapath.sv @@
// Datapath: configuration registers, raster counters, shared multiplier,
// restoring square root and two 8-step restoring dividers. Depends on rgcp_pkg.
module rgcp_datapath #(
  parameter int MAX_DIM        = 4096,
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rgcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                restart,
  input  rgcp_pkg::rgcp_cmd_t                 cmd,
  output rgcp_pkg::rgcp_status_t              status,
  output rgcp_pkg::rgcp_pixel_t               pixel
);

  localparam int RootW = rgcp_pkg::RAD_W + DIST_FRAC_BITS;
  localparam int OpW   = 2 * RootW;
  localparam int RemW  = RootW + 2;
  localparam int ProdW = RootW + rgcp_pkg::SCALE_W;
  localparam logic [16:0] MaxDimV = 17'(MAX_DIM);

  // Configuration
  logic [rgcp_pkg::DIM_W-1:0] frame_width;
  logic [rgcp_pkg::DIM_W-1:0] frame_height;
  logic [rgcp_pkg::POS_W-1:0] center_col;
  logic [rgcp_pkg::POS_W-1:0] center_row;
  logic [rgcp_pkg::RAD_W-1:0] circle_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= rgcp_pkg::WIDTH_RESET;
      frame_height  <= rgcp_pkg::HEIGHT_RESET;
      center_col    <= rgcp_pkg::CENTER_RESET;
      center_row    <= rgcp_pkg::CENTER_RESET;
      circle_radius <= rgcp_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rgcp_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        rgcp_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        rgcp_pkg::REG_CENTER_COL:    center_col    <= cfg_data[rgcp_pkg::POS_W-1:0];
        rgcp_pkg::REG_CENTER_ROW:    center_row    <= cfg_data[rgcp_pkg::POS_W-1:0];
        rgcp_pkg::REG_CIRCLE_RADIUS: circle_radius <= cfg_data[rgcp_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions and radius
  logic [rgcp_pkg::DIM_W-1:0] width_eff, height_eff, width_m1, height_m1;
  logic [rgcp_pkg::RAD_W-1:0] rad;
  logic [RootW-1:0]           rq;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = rgcp_pkg::DIM_W'(1);
    end else if ({4'b0, frame_width} > MaxDimV) begin
      width_eff = rgcp_pkg::DIM_W'(MAX_DIM);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height == '0) begin
      height_eff = rgcp_pkg::DIM_W'(1);
    end else if ({4'b0, frame_height} > MaxDimV) begin
      height_eff = rgcp_pkg::DIM_W'(MAX_DIM);
    end else begin
      height_eff = frame_height;
    end
    width_m1  = width_eff - rgcp_pkg::DIM_W'(1);
    height_m1 = height_eff - rgcp_pkg::DIM_W'(1);
    rad       = (circle_radius == '0) ? rgcp_pkg::RAD_W'(1) : circle_radius;
    rq        = {rad, {DIST_FRAC_BITS{1'b0}}};
  end

  // Raster counters
  logic [rgcp_pkg::COL_W-1:0] col;
  logic [rgcp_pkg::ROW_W-1:0] row;
  logic                       active;
  logic                       last;
  logic [rgcp_pkg::COL_W-1:0] dx;
  logic [rgcp_pkg::ROW_W-1:0] dy;
  logic                       row_end;

  assign row_end = (col >= width_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      active <= 1'b0;
    end else if (cmd.step) begin
      if (restart || !active) begin
        col    <= '0;
        row    <= rgcp_pkg::ROW_W'(height_m1);
        active <= 1'b1;
      end else if (row_end) begin
        col <= '0;
        row <= row - rgcp_pkg::ROW_W'(1);
      end else begin
        col <= col + rgcp_pkg::COL_W'(1);
      end
    end else if (cmd.diff && row_end && (row == '0)) begin
      // frame done: the next item starts a new one
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx   <= (col >= {1'b0, center_col}) ? col - {1'b0, center_col}
                                          : {1'b0, center_col} - col;
      dy   <= (row >= {4'b0, center_row}) ? row - {4'b0, center_row}
                                          : {4'b0, center_row} - row;
      last <= row_end && (row == '0);
    end
  end

  // Shared multiplier, product registered
  logic [RootW-1:0]                 mul_a;
  logic [rgcp_pkg::SCALE_W-1:0]     mul_b;
  logic [ProdW-1:0]                 prod;
  logic [RootW-1:0]                 root;
  logic [RootW-1:0]                 dq;

  assign dq = (root > rq) ? rq : root;

  always_comb begin
    case (cmd.mul_sel)
      rgcp_pkg::MUL_DX: begin
        mul_a = RootW'(dx);
        mul_b = rgcp_pkg::SCALE_W'(dx);
      end
      rgcp_pkg::MUL_DY: begin
        mul_a = RootW'(dy);
        mul_b = rgcp_pkg::SCALE_W'(dy);
      end
      rgcp_pkg::MUL_RAD: begin
        mul_a = RootW'(rad);
        mul_b = rgcp_pkg::SCALE_W'(rad);
      end
      rgcp_pkg::MUL_DEN: begin
        mul_a = RootW'(rad);
        mul_b = rgcp_pkg::DEN_SCALE;
      end
      rgcp_pkg::MUL_BLUE: begin
        mul_a = dq;
        mul_b = rgcp_pkg::GRAD_SCALE;
      end
      rgcp_pkg::MUL_GREEN: begin
        mul_a = rq - dq;
        mul_b = rgcp_pkg::GRAD_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ProdW'(mul_a) * ProdW'(mul_b);
  end

  // Squared distance and circle test
  logic [rgcp_pkg::SUM_W-1:0] sum;
  logic                       in_circle;

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      sum <= prod[rgcp_pkg::SUM_W-1:0];
    end else if (cmd.sum_add) begin
      sum <= sum + prod[rgcp_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_circle <= 1'b0;
    end else if (cmd.cmp) begin
      in_circle <= (sum <= prod[rgcp_pkg::SUM_W-1:0]);
    end
  end

  assign status.in_circle = in_circle;

  // Restoring square root, one root bit per step
  logic [rgcp_pkg::DEN_W-1:0] den;
  logic [OpW-1:0]             sq_op;
  logic [RemW-1:0]            rem;
  logic [RemW-1:0]            rem_sh;
  logic [RemW-1:0]            trial;

  assign rem_sh = {rem[RootW-1:0], sq_op[OpW-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.den_load) begin
      den   <= prod[rgcp_pkg::DEN_W-1:0];
      // inside the circle the sum fits in twice the radius width
      sq_op <= {sum[2*rgcp_pkg::RAD_W-1:0], {(2*DIST_FRAC_BITS){1'b0}}};
      rem   <= '0;
      root  <= '0;
    end else if (cmd.sqrt_step) begin
      sq_op <= sq_op << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end

  // Two restoring dividers sharing one shifted divisor
  logic [rgcp_pkg::NUM_W-1:0]  nb, ng, dsh;
  logic [rgcp_pkg::CHAN_W-1:0] qb, qg;

  always_ff @(posedge clk) begin
    if (cmd.nb_load) begin
      nb <= prod[ProdW-1:DIST_FRAC_BITS];
    end else if (cmd.div_step && (nb >= dsh)) begin
      nb <= nb - dsh;
    end
    if (cmd.ng_load) begin
      ng  <= prod[ProdW-1:DIST_FRAC_BITS];
      dsh <= rgcp_pkg::NUM_W'(den) << (rgcp_pkg::QUO_W - 1);
      qb  <= '0;
      qg  <= '0;
    end else if (cmd.div_step) begin
      dsh <= dsh >> 1;
      qb  <= {qb[rgcp_pkg::CHAN_W-2:0], (nb >= dsh)};
      qg  <= {qg[rgcp_pkg::CHAN_W-2:0], (ng >= dsh)};
      if (ng >= dsh) begin
        ng <= ng - dsh;
      end
    end
  end

  always_comb begin
    pixel.frame_end = last;
    pixel.pixel_row = row[rgcp_pkg::POS_W-1:0];
    pixel.pixel_col = col[rgcp_pkg::POS_W-1:0];
    pixel.red       = in_circle ? '0 : rgcp_pkg::CHAN_FULL;
    pixel.green     = in_circle ? qg : '0;
    pixel.blue      = in_circle ? qb : '0;
  end

endmodule

@@ rtl/radial_gradient_circle_pattern.sv @@
// Top level of the radial gradient circle test-pattern generator.
// Instantiates rgcp_ctrl and rgcp_datapath and holds the output register; uses rgcp_pkg.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata[0] restart
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata red,green,blue,col,row; tlast
//   cfg       in         cfg_we                         cfg_index, cfg_data
//
// One item at a time. A pixel outside the circle skips the square root, the scaling
// multiplies and the divide and goes straight on to the output stage; one inside runs
// the restoring square root (12 + DIST_FRAC_BITS steps) and the 8-step divider.
// The next item is accepted while a finished pixel waits in the output register; a
// second finished pixel holds in the sequencer until that one drains, stalling the input.
// rst is synchronous and restores the register defaults; there is no clearing pass.
module radial_gradient_circle_pattern #(
  parameter int MAX_DIM        = 4096,
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [0] restart
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [35:24] pixel_col, [47:36] pixel_row
  output logic [47:0]                      m_axis_tdata,
  output logic                             m_axis_tlast,   // frame_end
  input  logic                             cfg_we,
  input  logic [rgcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgcp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RootW = rgcp_pkg::RAD_W + DIST_FRAC_BITS;

  rgcp_pkg::rgcp_cmd_t    cmd;
  rgcp_pkg::rgcp_status_t status;
  rgcp_pkg::rgcp_pixel_t  pixel;
  logic                   out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  rgcp_ctrl #(
    .ROOT_W (RootW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  rgcp_datapath #(
    .MAX_DIM        (MAX_DIM),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (s_axis_tdata[0]),
    .cmd       (cmd),
    .status    (status),
    .pixel     (pixel)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {pixel.pixel_row, pixel.pixel_col, pixel.blue, pixel.green, pixel.red};
      m_axis_tlast <= pixel.frame_end;
    end
  end

`ifndef SYNTH
  // one item in flight: an accept is never followed directly by another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // red is all or nothing
  a_red_levels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[7:0] == 8'd255))
    else $error("red channel not 0 or 255");

  // outside pixels carry no gradient
  a_outside_pure: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[7:0] == 8'd255) |-> (m_axis_tdata[23:8] == 16'd0))
    else $error("outside pixel has green or blue");

  // inside pixels: green and blue split the full scale
  a_inside_sum: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0) |->
      (({1'b0, m_axis_tdata[15:8]} + {1'b0, m_axis_tdata[23:16]}) == 9'd255) ||
      (({1'b0, m_axis_tdata[15:8]} + {1'b0, m_axis_tdata[23:16]}) == 9'd254))
    else $error("green plus blue off the gradient");

  // the frame ends on the bottom row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[47:36] == 12'd0))
    else $error("frame end off row zero");
`endif

endmodule

@@ tb/radial_gradient_circle_pattern_tb.sv @@
// Self-checking testbench for radial_gradient_circle_pattern: restart/advance items in,
// colored pixels with raster position and frame-end flag out, all checked against a
// local pixel predictor. Depends on rgcp_pkg and the RTL top level only.
module radial_gradient_circle_pattern_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_LIMIT   = 4096;
  localparam int FRAC_BITS   = 8;
  localparam int ITEM_TARGET = 1200;
  localparam int STALL_LEN   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [rgcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rgcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  radial_gradient_circle_pattern #(
    .MAX_DIM(DIM_LIMIT),
    .DIST_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Local copy of the register file and raster state
  logic [rgcp_pkg::DIM_W-1:0] width_reg  = rgcp_pkg::WIDTH_RESET;
  logic [rgcp_pkg::DIM_W-1:0] height_reg = rgcp_pkg::HEIGHT_RESET;
  logic [rgcp_pkg::POS_W-1:0] ctr_col_reg = rgcp_pkg::CENTER_RESET;
  logic [rgcp_pkg::POS_W-1:0] ctr_row_reg = rgcp_pkg::CENTER_RESET;
  logic [rgcp_pkg::RAD_W-1:0] radius_reg = rgcp_pkg::RADIUS_RESET;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  bit in_frame = 1'b0;

  bit restart_q[$];
  rgcp_pkg::rgcp_pixel_t pixel_q[$];

  int src_idle_pct = 30;
  int sink_idle_pct = 48;
  bit stall_arm = 1'b0;
  bit stall_done;
  int stall_left;

  int items_sent = 0;
  int restarts_sent = 0;
  int pixels_checked = 0;
  int inside_pixels = 0;
  int frames_done = 0;
  int mismatches = 0;

  function automatic int unsigned eff_dim(logic [rgcp_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Advance the raster position and color the pixel it lands on
  function automatic rgcp_pkg::rgcp_pixel_t next_pixel(bit restart);
    int unsigned w;
    int unsigned h;
    longint unsigned rad;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned dist2;
    longint unsigned rq;
    longint unsigned dq;
    longint unsigned den;
    rgcp_pkg::rgcp_pixel_t px;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    rad = (radius_reg == 0) ? 1 : radius_reg;
    if (restart || !in_frame) begin
      col_pos = 0;
      row_pos = h - 1;
      in_frame = 1'b1;
    end else if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos - 1) & 32'hFFFF;
    end else begin
      col_pos = col_pos + 1;
    end
    dx = (col_pos >= ctr_col_reg) ? col_pos - ctr_col_reg : ctr_col_reg - col_pos;
    dy = (row_pos >= ctr_row_reg) ? row_pos - ctr_row_reg : ctr_row_reg - row_pos;
    dist2 = dx * dx + dy * dy;
    px.red = rgcp_pkg::CHAN_FULL;
    px.green = '0;
    px.blue = '0;
    if (dist2 <= rad * rad) begin
      rq = rad << FRAC_BITS;
      dq = floor_sqrt(dist2 << (2 * FRAC_BITS));
      if (dq > rq) dq = rq;
      den = rq * 1000;
      px.red = '0;
      px.blue = 8'(dq * 255999 / den);
      px.green = 8'((rq - dq) * 255999 / den);
    end
    px.pixel_col = col_pos[rgcp_pkg::POS_W-1:0];
    px.pixel_row = row_pos[rgcp_pkg::POS_W-1:0];
    px.frame_end = (col_pos >= w - 1) && (row_pos == 0);
    if (px.frame_end) in_frame = 1'b0;
    return px;
  endfunction

  function automatic bit next_pixel_inside(rgcp_pkg::rgcp_pixel_t px);
    return px.red == 0;
  endfunction

  // Sender: offer queued items, predict each one on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        pixel_q.push_back(next_pixel(s_axis_tdata[0]));
        if (next_pixel_inside(pixel_q[$])) inside_pixels++;
      end
      if (restart_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tdata <= {7'b0, restart_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with a single long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left != 0) stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left <= 1) && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: compare every accepted pixel with the oldest prediction
  always @(posedge clk) begin
    rgcp_pkg::rgcp_pixel_t got;
    rgcp_pkg::rgcp_pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.red = m_axis_tdata[7:0];
      got.green = m_axis_tdata[15:8];
      got.blue = m_axis_tdata[23:16];
      got.pixel_col = m_axis_tdata[35:24];
      got.pixel_row = m_axis_tdata[47:36];
      got.frame_end = m_axis_tlast;
      if (got.frame_end) frames_done++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel at col %0d row %0d", got.pixel_col, got.pixel_row);
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
            got.pixel_col != want.pixel_col || got.pixel_row != want.pixel_row ||
            got.frame_end != want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"pixel mismatch: expected rgb %0d,%0d,%0d col %0d row %0d last %0d,",
                      " got rgb %0d,%0d,%0d col %0d row %0d last %0d"},
                     want.red, want.green, want.blue, want.pixel_col, want.pixel_row,
                     want.frame_end, got.red, got.green, got.blue, got.pixel_col,
                     got.pixel_row, got.frame_end);
        end
      end
    end
  end

  // Hold until no item is queued, offered or awaiting its pixel
  task automatic settle();
    @(negedge clk);
    while (restart_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [rgcp_pkg::CFG_IDX_W-1:0] idx,
                           logic [rgcp_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      rgcp_pkg::REG_FRAME_WIDTH:   width_reg = val;
      rgcp_pkg::REG_FRAME_HEIGHT:  height_reg = val;
      rgcp_pkg::REG_CENTER_COL:    ctr_col_reg = val[rgcp_pkg::POS_W-1:0];
      rgcp_pkg::REG_CENTER_ROW:    ctr_row_reg = val[rgcp_pkg::POS_W-1:0];
      rgcp_pkg::REG_CIRCLE_RADIUS: radius_reg = val[rgcp_pkg::RAD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(int w, int h, int cc, int cr, int rad);
    settle();
    write_reg(rgcp_pkg::REG_FRAME_WIDTH, rgcp_pkg::CFG_DATA_W'(w));
    write_reg(rgcp_pkg::REG_FRAME_HEIGHT, rgcp_pkg::CFG_DATA_W'(h));
    write_reg(rgcp_pkg::REG_CENTER_COL, rgcp_pkg::CFG_DATA_W'(cc));
    write_reg(rgcp_pkg::REG_CENTER_ROW, rgcp_pkg::CFG_DATA_W'(cr));
    write_reg(rgcp_pkg::REG_CIRCLE_RADIUS, rgcp_pkg::CFG_DATA_W'(rad));
    cfg_we <= 1'b0;
  endtask

  task automatic push(bit restart);
    restart_q.push_back(restart);
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic random_phase();
    int n;
    int restart_pct;
    bit big;
    logic [rgcp_pkg::CFG_DATA_W-1:0] vals[5];
    big = ($urandom_range(7) == 0);
    if (big) begin
      foreach (vals[k]) vals[k] = rgcp_pkg::CFG_DATA_W'($urandom_range(8191, 0));
    end else begin
      vals[0] = rgcp_pkg::CFG_DATA_W'($urandom_range(12, 0));
      vals[1] = rgcp_pkg::CFG_DATA_W'($urandom_range(10, 0));
      vals[2] = rgcp_pkg::CFG_DATA_W'($urandom_range(14, 0));
      vals[3] = rgcp_pkg::CFG_DATA_W'($urandom_range(12, 0));
      vals[4] = rgcp_pkg::CFG_DATA_W'($urandom_range(9, 0));
    end
    settle();
    // Leave some registers alone so the raster continues across the change
    foreach (vals[k])
      if ($urandom_range(4) != 0) write_reg(rgcp_pkg::CFG_IDX_W'(k), vals[k]);
    cfg_we <= 1'b0;
    if (items_sent < ITEM_TARGET / 3) begin
      src_idle_pct = 30;
      sink_idle_pct = 48;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      src_idle_pct = 48;
      sink_idle_pct = 30;
    end else begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end
    if (big) n = $urandom_range(30, 5);
    else n = eff_dim(width_reg) * eff_dim(height_reg) * $urandom_range(2, 1)
             + $urandom_range(2, 0);
    if (n > 48) n = 48;
    restart_pct = ($urandom_range(3) == 0) ? 25 : 2;
    if (!stall_arm && items_sent >= ITEM_TARGET / 2) begin
      stall_arm = 1'b1;
      if (n < 24) n = 24;
    end
    repeat (n) push($urandom_range(99) < restart_pct);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: start from an idle raster, then restart it
    push(1'b0);
    push(1'b1);
    push(1'b0);
    push(1'b0);
    // Tiny frame around a center on the bottom row: center, edge and outside pixels
    set_all(3, 2, 1, 0, 1);
    push(1'b1);
    repeat (6) push(1'b0);
    // Zero dimensions and radius act as one
    set_all(0, 0, 0, 0, 0);
    push(1'b0);
    push(1'b0);
    push(1'b1);
    // Largest distance exactly on a full-size radius
    set_all(8191, 4096, 0, 0, 4095);
    push(1'b1);
    push(1'b0);
    set_all(4097, 8191, 13'h1FFF, 4095, 4095);
    push(1'b1);
    push(1'b0);
    // Farthest pixel from the center; writes to unused indexes must not land
    settle();
    for (int k = rgcp_pkg::REG_CIRCLE_RADIUS + 1; k < 2 ** rgcp_pkg::CFG_IDX_W; k++)
      write_reg(rgcp_pkg::CFG_IDX_W'(k), rgcp_pkg::CFG_DATA_W'($urandom_range(8191, 0)));
    cfg_we <= 1'b0;
    set_all(2, 4096, 4095, 0, 4095);
    push(1'b1);
    push(1'b0);

    while (items_sent < ITEM_TARGET) random_phase();

    settle();
    repeat (45) @(posedge clk);
    $display("%0d items (%0d restarts), %0d pixels checked, %0d inside the circle",
             items_sent, restarts_sent, pixels_checked, inside_pixels);
    $display("%0d frames completed, %0d mismatches", frames_done, mismatches);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d pixels outstanding", pixel_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rgcp_pkg.sv
rtl/rgcp_ctrl.sv
rtl/rgcp_datapath.sv
rtl/radial_gradient_circle_pattern.sv
tb/radial_gradient_circle_pattern_tb.sv
